[hdl/cheat_code_string_decoder_macros.svh]
// Assertion macros shared by the cheat code decoder checkers.
// Expects signals named clock and reset in the scope of use.
`ifndef CHEAT_CODE_STRING_DECODER_MACROS_SVH
`define CHEAT_CODE_STRING_DECODER_MACROS_SVH

// clocked property, switched off while reset is high
`define CCSD_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// clocked property that also holds across reset
`define CCSD_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

[hdl/ccsd_pkg.sv]
// Package for the cheat code string decoder: widths, status codes,
// character constants and the letter / hex lookup functions. No dependencies.
`default_nettype none

package ccsd_pkg;

   // channel widths
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 40;
   localparam int RSP_USER_W = 2;

   localparam int CHAR_W  = 8;
   localparam int COUNT_W = 4;
   localparam int WORD_W  = 32;
   localparam int ADDR_W  = 24;
   localparam int VALUE_W = 8;

   // character count saturates here; lengths of the two accepted forms
   localparam logic [COUNT_W-1:0] COUNT_SAT   = 4'd10;
   localparam logic [COUNT_W-1:0] LEN_GENIE   = 4'd9;
   localparam logic [COUNT_W-1:0] LEN_RAW     = 4'd8;
   localparam logic [COUNT_W-1:0] DASH_INDEX  = 4'd4;

   // ASCII codes
   localparam logic [CHAR_W-1:0] CHAR_DASH    = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_0       = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_9       = 8'h39;
   localparam logic [CHAR_W-1:0] CHAR_UA      = 8'h41;
   localparam logic [CHAR_W-1:0] CHAR_UF      = 8'h46;
   localparam logic [CHAR_W-1:0] CHAR_LA      = 8'h61;
   localparam logic [CHAR_W-1:0] CHAR_LZ      = 8'h7A;
   localparam logic [CHAR_W-1:0] CASE_OFFSET  = 8'h20;

   // work RAM mirror window 0x7E0000..0x7E1FFF, compared on address bits 23:13
   localparam int MIRROR_LSB = 13;
   localparam logic [ADDR_W-MIRROR_LSB-1:0] MIRROR_PAGE = 11'h3F0;

   typedef enum logic [RSP_USER_W-1:0] {
      ST_GENIE  = 2'd0,
      ST_RAW    = 2'd1,
      ST_REJECT = 2'd2
   } status_type;

   typedef struct packed {
      logic               hit;
      logic [3:0]         nib;
   } nibble_type;

   // Game Genie letter table "DF4709156BC8A23E"
   function automatic nibble_type genie_lookup(input logic [CHAR_W-1:0] c);
      nibble_type r;
      r.hit = 1'b1;
      case (c)
         8'h44:   r.nib = 4'h0; // D
         8'h46:   r.nib = 4'h1; // F
         8'h34:   r.nib = 4'h2; // 4
         8'h37:   r.nib = 4'h3; // 7
         8'h30:   r.nib = 4'h4; // 0
         8'h39:   r.nib = 4'h5; // 9
         8'h31:   r.nib = 4'h6; // 1
         8'h35:   r.nib = 4'h7; // 5
         8'h36:   r.nib = 4'h8; // 6
         8'h42:   r.nib = 4'h9; // B
         8'h43:   r.nib = 4'hA; // C
         8'h38:   r.nib = 4'hB; // 8
         8'h41:   r.nib = 4'hC; // A
         8'h32:   r.nib = 4'hD; // 2
         8'h33:   r.nib = 4'hE; // 3
         8'h45:   r.nib = 4'hF; // E
         default: begin
            r.hit = 1'b0;
            r.nib = 4'h0;
         end
      endcase
      return r;
   endfunction

   // upper-case hex digit to nibble
   function automatic nibble_type hex_lookup(input logic [CHAR_W-1:0] c);
      nibble_type  r;
      logic [CHAR_W-1:0] d;
      d = 8'h00;
      r.hit = 1'b0;
      if (c >= CHAR_0 && c <= CHAR_9) begin
         d = c - CHAR_0;
         r.hit = 1'b1;
      end else if (c >= CHAR_UA && c <= CHAR_UF) begin
         d = c - CHAR_UA + 8'd10;
         r.hit = 1'b1;
      end
      r.nib = d[3:0];
      return r;
   endfunction

   // Game Genie bit shuffle of the low 24 bits into the address
   function automatic logic [ADDR_W-1:0] genie_address(input logic [WORD_W-1:0] w);
      return {w[13:10], w[5:2], w[23:20], w[1:0], w[15:14], w[19:16], w[9:6]};
   endfunction

endpackage

`default_nettype wire

[hdl/cheat_code_string_decoder.sv]
// Cheat code string decoder top level: character accumulators, decode and
// a two-entry output stage (result register plus skid). Uses ccsd_pkg.
`default_nettype none
//
//  channel | dir | handshake          | beat contents
//  req     | in  | req_tvalid/tready  | one ASCII character, tlast on final one
//  rsp     | out | rsp_tvalid/tready  | status in tuser, address/value/mirror
//
//  One character per cycle while req_tready is high. The decode of a string is
//  registered when the character carrying tlast is taken: into the result
//  register, or into the skid slot if the output is stalled, so input keeps
//  flowing; req_tready drops only while the skid slot holds a result.
//  Reset (synchronous, high) clears the accumulators and both output slots.

module cheat_code_string_decoder (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [ccsd_pkg::REQ_DATA_W-1:0] req_tdata,  // [7:0] character
   input  logic                          req_tlast,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [ccsd_pkg::RSP_DATA_W-1:0] rsp_tdata,  // [23:0] address, [31:24] value,
                                                       // [32] workram_mirror, rest zero
   output logic [ccsd_pkg::RSP_USER_W-1:0] rsp_tuser   // [1:0] status
);
   import ccsd_pkg::*;

   typedef struct packed {
      status_type          status;
      logic [ADDR_W-1:0]   address;
      logic [VALUE_W-1:0]  value;
      logic                mirror;
   } result_type;

   // accumulator state
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [WORD_W-1:0]  genie_ff, genie_in;
   logic [WORD_W-1:0]  hex_ff, hex_in;
   logic               genie_bad_ff, genie_bad_in;
   logic               hex_bad_ff, hex_bad_in;
   logic               dash5_ff, dash5_in;

   // output stage
   logic       out_valid_ff, out_valid_in;
   result_type out_ff, out_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type skid_ff, skid_in;

   logic              accept;
   logic [CHAR_W-1:0] c_up;
   nibble_type        gnib, hnib;
   logic [COUNT_W-1:0] count_step;
   logic [WORD_W-1:0] genie_step, hex_step;
   logic              genie_bad_step, hex_bad_step, dash5_step;
   result_type        res;
   logic              out_free;

   assign req_tready = !skid_valid_ff;
   assign accept     = req_tvalid && req_tready;

   // upper-case and per-character lookups
   always_comb begin
      c_up = req_tdata;
      if (req_tdata >= CHAR_LA && req_tdata <= CHAR_LZ) begin
         c_up = req_tdata - CASE_OFFSET;
      end
      gnib = genie_lookup(c_up);
      hnib = hex_lookup(c_up);
   end

   // state after this character
   always_comb begin
      genie_step     = genie_ff;
      genie_bad_step = genie_bad_ff;
      dash5_step     = dash5_ff;
      if (c_up == CHAR_DASH) begin
         if (count_ff == DASH_INDEX) begin
            dash5_step = 1'b1;
         end
      end else if (gnib.hit) begin
         genie_step = {genie_ff[WORD_W-5:0], gnib.nib};
      end else begin
         genie_bad_step = 1'b1;
      end
      hex_step     = hex_ff;
      hex_bad_step = hex_bad_ff;
      if (hnib.hit) begin
         hex_step = {hex_ff[WORD_W-5:0], hnib.nib};
      end else begin
         hex_bad_step = 1'b1;
      end
      count_step = (count_ff < COUNT_SAT) ? count_ff + 4'd1 : count_ff;
   end

   // decode of the completed string
   always_comb begin
      res.status  = ST_REJECT;
      res.address = '0;
      res.value   = '0;
      if (count_step == LEN_GENIE && dash5_step) begin
         if (!genie_bad_step) begin
            res.status  = ST_GENIE;
            res.address = genie_address(genie_step);
            res.value   = genie_step[WORD_W-1:WORD_W-VALUE_W];
         end
      end else if (count_step == LEN_RAW && !hex_bad_step) begin
         res.status  = ST_RAW;
         res.address = hex_step[WORD_W-1:VALUE_W];
         res.value   = hex_step[VALUE_W-1:0];
      end
      res.mirror = (res.status != ST_REJECT) &&
                   (res.address[ADDR_W-1:MIRROR_LSB] == MIRROR_PAGE);
   end

   // accumulator next state; cleared after the final character
   always_comb begin
      count_in     = count_ff;
      genie_in     = genie_ff;
      hex_in       = hex_ff;
      genie_bad_in = genie_bad_ff;
      hex_bad_in   = hex_bad_ff;
      dash5_in     = dash5_ff;
      if (accept) begin
         if (req_tlast) begin
            count_in     = '0;
            genie_in     = '0;
            hex_in       = '0;
            genie_bad_in = 1'b0;
            hex_bad_in   = 1'b0;
            dash5_in     = 1'b0;
         end else begin
            count_in     = count_step;
            genie_in     = genie_step;
            hex_in       = hex_step;
            genie_bad_in = genie_bad_step;
            hex_bad_in   = hex_bad_step;
            dash5_in     = dash5_step;
         end
      end
   end

   // result register with skid slot
   always_comb begin
      out_free      = !out_valid_ff || rsp_tready;
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else if (accept && req_tlast) begin
            out_valid_in = 1'b1;
            out_in       = res;
         end else begin
            out_valid_in = 1'b0;
         end
      end else if (accept && req_tlast) begin
         skid_valid_in = 1'b1;
         skid_in       = res;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         genie_ff      <= '0;
         hex_ff        <= '0;
         genie_bad_ff  <= 1'b0;
         hex_bad_ff    <= 1'b0;
         dash5_ff      <= 1'b0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         genie_ff      <= genie_in;
         hex_ff        <= hex_in;
         genie_bad_ff  <= genie_bad_in;
         hex_bad_ff    <= hex_bad_in;
         dash5_ff      <= dash5_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ff.status;
   assign rsp_tdata  = {{(RSP_DATA_W-ADDR_W-VALUE_W-1){1'b0}},
                        out_ff.mirror, out_ff.value, out_ff.address};

endmodule

`default_nettype wire

[hdl/ccsd_checker.sv]
// Port-level checker for the cheat code string decoder, bound to the top.
// Uses ccsd_pkg and cheat_code_string_decoder_macros.svh.
`default_nettype none
`include "cheat_code_string_decoder_macros.svh"

module ccsd_checker (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            rsp_tvalid,
   input  wire                            rsp_tready,
   input  wire [ccsd_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  wire [ccsd_pkg::RSP_USER_W-1:0] rsp_tuser
);
   import ccsd_pkg::*;

   logic rejected;
   logic valid_code;
   logic mirror_flag;
   logic in_window;
   logic rsp_stall;
   logic [RSP_DATA_W+RSP_USER_W-1:0] rsp_beat;

   assign rejected    = rsp_tuser == ST_REJECT;
   assign valid_code  = rsp_tuser == ST_GENIE || rsp_tuser == ST_RAW || rejected;
   assign mirror_flag = rsp_tdata[ADDR_W+VALUE_W];
   assign in_window   = rsp_tdata[ADDR_W-1:MIRROR_LSB] == MIRROR_PAGE;
   assign rsp_stall   = rsp_tvalid && !rsp_tready;
   assign rsp_beat    = {rsp_tuser, rsp_tdata};

   // a rejected string carries an all-zero payload
   `CCSD_ASSERT(a_reject_zero, rsp_tvalid && rejected |-> rsp_tdata == '0, "reject with payload")
   // mirror flag only inside the work RAM window
   `CCSD_ASSERT(a_mirror_range, rsp_tvalid && mirror_flag |-> in_window && !rejected, "mirror outside window")
   // status is one of the three codes
   `CCSD_ASSERT(a_status_code, rsp_tvalid |-> valid_code, "bad status code")
   // no result straight out of reset
   `CCSD_ASSERT_ALWAYS(a_reset_quiet, reset |=> !rsp_tvalid, "result after reset")
   // a stalled result beat holds
   `CCSD_ASSERT(a_rsp_hold, rsp_stall |=> rsp_tvalid && $stable(rsp_beat), "stalled beat changed")

endmodule

bind cheat_code_string_decoder ccsd_checker u_ccsd_checker (.*);

`default_nettype wire

[tb/tb_cheat_code_string_decoder.sv]
`timescale 1ns / 100ps
// Self-checking bench for the cheat code string decoder: streams cheat strings
// a character per beat and checks each decode against a local model of the block.
// Depends on ccsd_pkg and the cheat_code_string_decoder RTL only.

module tb_cheat_code_string_decoder;
   import ccsd_pkg::*;

   localparam int ITEM_TARGET = 550;
   localparam int HOLD_AT     = 40;     // result count at which the sink stalls hard
   localparam int LONG_HOLD   = 300;
   localparam int IDLE_LIMIT  = 3000;
   localparam int TAIL_CYCLES = 20;

   localparam logic [127:0]        GENIE_LETTERS = "DF4709156BC8A23E";
   localparam logic [ADDR_W-1:0]   MIRROR_LO     = 24'h7E0000;
   localparam logic [ADDR_W-1:0]   MIRROR_HI     = 24'h7E2000;
   localparam logic [CHAR_W-1:0]   CHAR_7        = 8'h37;
   localparam logic [CHAR_W-1:0]   CHAR_UE       = 8'h45;

   typedef struct {
      logic [CHAR_W-1:0] ch;
      bit                fin;
      bit                drain;  // wait for all decodes before offering this beat
   } char_beat_t;

   typedef struct packed {
      status_type          status;
      logic [ADDR_W-1:0]   address;
      logic [VALUE_W-1:0]  value;
      logic                mirror;
   } decode_t;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;   // [7:0] character
   logic                  req_tlast = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;        // [23:0] address, [31:24] value, [32] mirror
   logic [RSP_USER_W-1:0] rsp_tuser;        // [1:0] status

   // string buffer and the two queues
   logic [CHAR_W-1:0] text_buf[$];
   char_beat_t        char_q[$];
   decode_t           decoded_q[$];

   // decoder state as the block should hold it
   logic [COUNT_W-1:0] seen_chars;
   logic [WORD_W-1:0]  genie_acc;
   logic [WORD_W-1:0]  hex_acc;
   bit                 genie_miss;
   bit                 hex_miss;
   bit                 dash_fifth;

   int         items_queued = 0;
   int         beats_sent = 0;
   int         results_seen = 0;
   int         failures = 0;
   int         n_genie = 0;
   int         n_raw = 0;
   int         n_reject = 0;
   int         gap_left = 0;
   int         stall_left = 0;
   int         idle_cycles = 0;
   char_beat_t nxt;
   decode_t    want;

   cheat_code_string_decoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
   end

   function automatic void clear_decoder();
      seen_chars = '0;
      genie_acc  = '0;
      hex_acc    = '0;
      genie_miss = 1'b0;
      hex_miss   = 1'b0;
      dash_fifth = 1'b0;
   endfunction

   // advance the decoder by one character; on the final one, queue the decode
   function automatic void decode_char(input logic [CHAR_W-1:0] raw, input bit fin);
      logic [CHAR_W-1:0] c;
      logic [CHAR_W-1:0] d;
      logic [WORD_W-1:0] w;
      logic [WORD_W-1:0] a;
      int                slot;
      decode_t           r;
      c = raw;
      if (c >= CHAR_LA && c <= CHAR_LZ) c = c - CASE_OFFSET;

      // letter-table word; dashes add nothing
      if (c == CHAR_DASH) begin
         if (seen_chars == DASH_INDEX) dash_fifth = 1'b1;
      end else begin
         slot = -1;
         for (int i = 15; i >= 0; i--)
            if (GENIE_LETTERS[127-8*i -: 8] == c) slot = i;
         if (slot < 0) genie_miss = 1'b1;
         else genie_acc = {genie_acc[WORD_W-5:0], slot[3:0]};
      end

      // plain hex word
      if (c >= CHAR_0 && c <= CHAR_9) begin
         d = c - CHAR_0;
         hex_acc = {hex_acc[WORD_W-5:0], d[3:0]};
      end else if (c >= CHAR_UA && c <= CHAR_UF) begin
         d = c - CHAR_UA + 8'd10;
         hex_acc = {hex_acc[WORD_W-5:0], d[3:0]};
      end else begin
         hex_miss = 1'b1;
      end

      if (seen_chars < COUNT_SAT) seen_chars = seen_chars + 1'b1;
      if (!fin) return;

      r.status  = ST_REJECT;
      r.address = '0;
      r.value   = '0;
      if (seen_chars == LEN_GENIE && dash_fifth) begin
         if (!genie_miss) begin
            w = genie_acc;
            a = ((w & 32'h3C00) << 10) | ((w & 32'h3C) << 14) | ((w & 32'hF00000) >> 8) |
                ((w & 32'h03) << 10) | ((w & 32'hC000) >> 6) | ((w & 32'hF0000) >> 12) |
                ((w & 32'h3C0) >> 6);
            r.address = a[ADDR_W-1:0];
            r.value   = w[31:24];
            r.status  = ST_GENIE;
         end
      end else if (seen_chars == LEN_RAW && !hex_miss) begin
         r.address = hex_acc[31:8];
         r.value   = hex_acc[7:0];
         r.status  = ST_RAW;
      end
      r.mirror = (r.status != ST_REJECT) && r.address >= MIRROR_LO && r.address < MIRROR_HI;
      decoded_q = {decoded_q, r};
      clear_decoder();
   endfunction

   // mostly no gap, some short, a few long; regular stretches with none at all
   function automatic int pick_gap(input int n);
      int r;
      if ((n % 160) < 40) return 0;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [CHAR_W-1:0] genie_char();
      int i;
      i = $urandom_range(0, 15);
      return GENIE_LETTERS[127-8*i -: 8];
   endfunction

   function automatic logic [CHAR_W-1:0] hex_char();
      int i;
      i = $urandom_range(0, 15);
      if (i < 10) return CHAR_0 + 8'(i);
      return CHAR_UA + 8'(i - 10);
   endfunction

   // lower-case A..F half of the time
   function automatic logic [CHAR_W-1:0] case_mix(input logic [CHAR_W-1:0] c);
      if (c >= CHAR_UA && c <= CHAR_UF && $urandom_range(0, 1) == 1) return c + CASE_OFFSET;
      return c;
   endfunction

   // append one character to the string being built
   function automatic void add_char(input logic [CHAR_W-1:0] c);
      text_buf = {text_buf, c};
   endfunction

   // move text_buf into the pending beats, tlast on its final character
   task automatic queue_chars(input bit drain);
      char_beat_t b;
      foreach (text_buf[i]) begin
         b.ch    = text_buf[i];
         b.fin   = (i == text_buf.size() - 1);
         b.drain = (drain && i == 0);
         char_q  = {char_q, b};
         items_queued++;
      end
   endtask

   task automatic queue_text(input string s);
      text_buf.delete();
      for (int i = 0; i < s.len(); i++) add_char(s[i]);
      queue_chars(1'b0);
   endtask

   // stimulus and end of run
   initial begin
      int kind;
      int len;
      int pos;
      int strings;

      // directed strings
      queue_text("eeee-EEEE");      // all-ones code, lower case
      queue_text("DDDD-DDDD");      // all-zeros code
      queue_text("7e1fff00");       // raw, top of the mirror window
      queue_text("DF47-09G5");      // letter outside the table
      queue_text("-DF4-7091");      // extra dash elsewhere is skipped
      queue_text("0123456789A");    // overlong, count saturates
      queue_text("1234-567");       // eight long but holds a dash
      text_buf = {8'hFF};           // lone non-ASCII byte
      queue_chars(1'b0);

      // random strings
      strings = 0;
      while (items_queued < ITEM_TARGET) begin
         text_buf.delete();
         kind = $urandom_range(0, 99);
         if (kind < 40) begin
            for (int i = 0; i < 9; i++)
               add_char(i == 4 ? CHAR_DASH : case_mix(genie_char()));
         end else if (kind < 70) begin
            for (int i = 0; i < 8; i++) add_char(case_mix(hex_char()));
            // steer some raw codes at the mirror window and just past it
            if ($urandom_range(0, 3) == 0) begin
               text_buf[0] = CHAR_7;
               text_buf[1] = case_mix(CHAR_UE);
               text_buf[2] = CHAR_0 + 8'($urandom_range(0, 2));
            end
         end else if (kind < 78) begin
            for (int i = 0; i < 9; i++)
               add_char(i == 4 ? CHAR_DASH : case_mix(genie_char()));
            text_buf[$urandom_range(0, 8)] = 8'($urandom_range(0, 255));
         end else if (kind < 84) begin
            pos = $urandom_range(0, 7);
            if (pos >= 4) pos++;
            for (int i = 0; i < 9; i++) add_char(case_mix(genie_char()));
            text_buf[pos] = CHAR_DASH;
         end else if (kind < 90) begin
            len = $urandom_range(1, 12);
            if (len == 8) len = 9;
            for (int i = 0; i < len; i++) add_char(case_mix(hex_char()));
         end else begin
            len = $urandom_range(1, 14);
            for (int i = 0; i < len; i++) add_char(8'($urandom_range(0, 255)));
         end
         strings++;
         queue_chars(strings == 25 || strings == 70);
      end

      while (char_q.size() != 0 || req_tvalid || decoded_q.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (decoded_q.size() != 0) begin
         $error("%0d decodes never arrived", decoded_q.size());
         failures++;
      end
      $display("Sent %0d character beats; checked %0d decodes (%0d genie, %0d raw, %0d rejected)",
               beats_sent, results_seen, n_genie, n_raw, n_reject);
      if (failures == 0) begin
         $display("PASS cheat_code_string_decoder");
      end else begin
         $display("FAIL cheat_code_string_decoder");
      end
      $finish;
   end

   // driver: character beats out of char_q, model updated on each accepted beat
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         req_tlast  <= 1'b0;
         gap_left = 0;
         clear_decoder();
      end else begin
         if (req_tvalid && req_tready) begin
            decode_char(req_tdata, req_tlast);
            beats_sent++;
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (char_q.size() != 0 && !(char_q[0].drain && decoded_q.size() != 0)) begin
               nxt = char_q.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= nxt.ch;
               req_tlast  <= nxt.fin;
               gap_left = pick_gap(beats_sent);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor: each result beat against the oldest expected decode
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (decoded_q.size() == 0) begin
               $error("result beat with no decode pending: tuser %0d tdata %h",
                      rsp_tuser, rsp_tdata);
               failures++;
            end else begin
               want = decoded_q.pop_front();
               case (want.status)
                  ST_GENIE: n_genie++;
                  ST_RAW:   n_raw++;
                  default:  n_reject++;
               endcase
               if (rsp_tuser !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_tuser);
                  failures++;
               end
               if (rsp_tdata[23:0] !== want.address) begin
                  $error("address: expected %h, got %h", want.address, rsp_tdata[23:0]);
                  failures++;
               end
               if (rsp_tdata[31:24] !== want.value) begin
                  $error("value: expected %h, got %h", want.value, rsp_tdata[31:24]);
                  failures++;
               end
               if (rsp_tdata[32] !== want.mirror) begin
                  $error("workram_mirror: expected %0d, got %0d", want.mirror, rsp_tdata[32]);
                  failures++;
               end
            end
            results_seen++;
            stall_left = (results_seen == HOLD_AT) ? LONG_HOLD : pick_gap(results_seen);
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // watchdog on cycles with no beat on either channel
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
            if (idle_cycles == IDLE_LIMIT) begin
               $display("No beat for %0d cycles", IDLE_LIMIT);
               $display("FAIL cheat_code_string_decoder");
               $finish;
            end
         end
      end
   end

endmodule
